// File: src/gbn_pkg.sv
// Package for the Go-Back-N sender window core.
// Holds field widths, sequence constants, mode, kind and register codes.
// No dependencies; every other file imports it.
package gbn_pkg;

    // Field widths.
    localparam int SEQ_W  = 3;
    localparam int LEN_W  = 5;
    localparam int MODE_W = 2;
    localparam int KIND_W = 3;
    localparam int WIN_W  = 3;
    localparam int TMO_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Sequence space and payload limits.
    localparam int SEQ_MOD = 1 << SEQ_W;
    localparam logic [SEQ_W-1:0] SEQ_MASK = SEQ_W'(SEQ_MOD - 1);
    localparam int MAX_PAYLOAD = 30;

    // Register reset values.
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(7);
    localparam logic [TMO_W-1:0] TMO_RESET = TMO_W'(2000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = CFG_IDX_W'(1);

    // Input item modes.
    localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_END  = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_NEW     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RETX    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACK_OK  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ACK_IGN = 3'd5;

endpackage

// File: src/gbn_if.sv
// Valid/ready channel interfaces for the Go-Back-N sender window core.
// Depends on gbn_pkg for the field widths.
interface gbn_req_if;
    import gbn_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  payload_length;
    logic [SEQ_W-1:0]  ack_seq;

    modport source (output valid, output mode, output payload_length, output ack_seq,
                    input ready);
    modport sink   (input valid, input mode, input payload_length, input ack_seq,
                    output ready);
endinterface

interface gbn_res_if;
    import gbn_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  frame_seq;
    logic [LEN_W-1:0]  frame_length;
    logic [SEQ_W-1:0]  outstanding_count;
    logic [SEQ_W-1:0]  base_seq;
    logic              last;

    modport source (output valid, output kind, output frame_seq, output frame_length,
                    output outstanding_count, output base_seq, output last,
                    input ready);
    modport sink   (input valid, input kind, input frame_seq, input frame_length,
                    input outstanding_count, input base_seq, input last,
                    output ready);
endinterface

// File: src/go_back_n_sender_window_core.sv
// Go-Back-N sender window core: window state, length memory and resend sequencer.
// Depends on gbn_pkg and the channel interfaces in gbn_if.sv.
//
//   Channel | Direction | Payload
//   --------+-----------+--------------------------------------------------------
//   req     | in        | mode, payload_length, ack_seq
//   res     | out       | kind, frame_seq, frame_length, outstanding_count,
//           |           | base_seq, last
//   cfg     | in        | cfg_we, cfg_index, cfg_wdata (write only)
//
// Send, ack and end items each produce one result; a tick produces none unless it
// expires. An expiring tick resends the N outstanding frames: the length memory is
// read one frame per cycle unless stalled; each read is registered before it goes out.
// Reset clears the window state and the timer; the length memory is not cleared.
// A stalled result holds the output register; during a resend the sequencer
// waits on it and no new item is taken.
module go_back_n_sender_window_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    gbn_req_if.sink                            req,
    gbn_res_if.source                          res
);
    import gbn_pkg::*;

    typedef enum logic {ST_IDLE, ST_RETX} state_t;

    state_t            state_reg, state_next;
    logic [WIN_W-1:0]  win_reg;
    logic [TMO_W-1:0]  tmo_reg;
    logic [SEQ_W-1:0]  send_base_reg, send_base_next;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]  outstanding_reg, outstanding_next;
    logic [TMO_W-1:0]  timer_reg, timer_next;

    // Resend sequencer and memory read stage.
    logic [SEQ_W-1:0]  retx_left_reg, retx_left_next;
    logic [SEQ_W-1:0]  retx_seq_reg, retx_seq_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [SEQ_W-1:0]  rd_seq_reg;
    logic              rd_last_reg;
    logic [LEN_W-1:0]  rd_data_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0]  out_seq_reg, out_seq_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic [SEQ_W-1:0]  out_cnt_reg;
    logic [SEQ_W-1:0]  out_base_reg;
    logic              out_last_reg, out_last_next;

    logic [LEN_W-1:0]  len_store [SEQ_MOD];

    logic              out_free;
    logic              accept;
    logic              load_out;
    logic              mem_we;
    logic              rd_issue;
    logic [LEN_W-1:0]  plen_sat;
    logic [SEQ_W-1:0]  win_eff;
    logic [TMO_W-1:0]  limit;
    logic [TMO_W-1:0]  timer_inc;
    logic [SEQ_W-1:0]  ack_off;

    // Handshake: one item at a time, taken in the idle state while the output register can move.
    assign out_free  = !out_valid_reg || res.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    // Saturated length, effective window and timeout limit.
    assign plen_sat  = (req.payload_length > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                                    : req.payload_length;
    assign win_eff   = (SEQ_W'(win_reg) < SEQ_MASK) ? SEQ_W'(win_reg) : SEQ_MASK;
    assign limit     = (tmo_reg == '0) ? TMO_W'(1) : tmo_reg;
    assign timer_inc = (timer_reg == '1) ? timer_reg : timer_reg + TMO_W'(1);
    assign ack_off   = req.ack_seq - send_base_reg;

    // Next-state logic for the window, timer, sequencer and output register.
    always_comb
    begin
        state_next       = state_reg;
        send_base_next   = send_base_reg;
        next_seq_next    = next_seq_reg;
        outstanding_next = outstanding_reg;
        timer_next       = timer_reg;
        retx_left_next   = retx_left_reg;
        retx_seq_next    = retx_seq_reg;
        rd_valid_next    = rd_valid_reg;
        load_out         = 1'b0;
        mem_we           = 1'b0;
        rd_issue         = 1'b0;
        out_kind_next    = KIND_REJECT;
        out_seq_next     = next_seq_reg;
        out_len_next     = '0;
        out_last_next    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.mode)
                        MODE_SEND:
                        begin
                            load_out = 1'b1;
                            if (outstanding_reg < win_eff)
                            begin
                                mem_we           = 1'b1;
                                if (outstanding_reg == '0)
                                begin
                                    timer_next = '0;
                                end
                                next_seq_next    = next_seq_reg + SEQ_W'(1);
                                outstanding_next = outstanding_reg + SEQ_W'(1);
                                out_kind_next    = KIND_NEW;
                                out_len_next     = plen_sat;
                            end
                        end
                        MODE_ACK:
                        begin
                            load_out     = 1'b1;
                            out_seq_next = req.ack_seq;
                            if (ack_off < outstanding_reg)
                            begin
                                send_base_next   = req.ack_seq + SEQ_W'(1);
                                outstanding_next = outstanding_reg - ack_off - SEQ_W'(1);
                                timer_next       = '0;
                                out_kind_next    = KIND_ACK_OK;
                            end
                            else
                            begin
                                out_kind_next = KIND_ACK_IGN;
                            end
                        end
                        MODE_TICK:
                        begin
                            if (outstanding_reg == '0)
                            begin
                                timer_next = '0;
                            end
                            else if (timer_inc >= limit)
                            begin
                                timer_next     = '0;
                                retx_left_next = outstanding_reg;
                                retx_seq_next  = send_base_reg;
                                state_next     = ST_RETX;
                            end
                            else
                            begin
                                timer_next = timer_inc;
                            end
                        end
                        MODE_END:
                        begin
                            load_out = 1'b1;
                            if (outstanding_reg == '0)
                            begin
                                out_kind_next = KIND_END;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            ST_RETX:
            begin
                // Move a read frame into the output register when it is free.
                if (rd_valid_reg && out_free)
                begin
                    load_out      = 1'b1;
                    out_kind_next = KIND_RETX;
                    out_seq_next  = rd_seq_reg;
                    out_len_next  = rd_data_reg;
                    out_last_next = rd_last_reg;
                    rd_valid_next = 1'b0;
                    if (rd_last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                // Issue the next memory read once the read stage can take it.
                if ((retx_left_reg != '0) && (!rd_valid_reg || out_free))
                begin
                    rd_issue       = 1'b1;
                    rd_valid_next  = 1'b1;
                    retx_left_next = retx_left_reg - SEQ_W'(1);
                    retx_seq_next  = retx_seq_reg + SEQ_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            win_reg         <= WIN_RESET;
            tmo_reg         <= TMO_RESET;
            send_base_reg   <= '0;
            next_seq_reg    <= '0;
            outstanding_reg <= '0;
            timer_reg       <= '0;
            retx_left_reg   <= '0;
            retx_seq_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            send_base_reg   <= send_base_next;
            next_seq_reg    <= next_seq_next;
            outstanding_reg <= outstanding_next;
            timer_reg       <= timer_next;
            retx_left_reg   <= retx_left_next;
            retx_seq_reg    <= retx_seq_next;
            rd_valid_reg    <= rd_valid_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WINDOW)
                begin
                    win_reg <= cfg_wdata[WIN_W-1:0];
                end
                else if (cfg_index == CFG_TIMEOUT)
                begin
                    tmo_reg <= cfg_wdata[TMO_W-1:0];
                end
            end
        end
    end

    // Length memory: written by accepted sends, read by the resend sequencer.
    // The two never meet in one cycle because no item is taken during a resend.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            len_store[next_seq_reg] <= plen_sat;
        end
        if (rd_issue)
        begin
            rd_data_reg <= len_store[retx_seq_reg];
            rd_seq_reg  <= retx_seq_reg;
            rd_last_reg <= (retx_left_reg == SEQ_W'(1));
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_kind_reg <= out_kind_next;
            out_seq_reg  <= out_seq_next;
            out_len_reg  <= out_len_next;
            out_cnt_reg  <= outstanding_next;
            out_base_reg <= send_base_next;
            out_last_reg <= out_last_next;
        end
    end

    assign res.valid             = out_valid_reg;
    assign res.kind              = out_kind_reg;
    assign res.frame_seq         = out_seq_reg;
    assign res.frame_length      = out_len_reg;
    assign res.outstanding_count = out_cnt_reg;
    assign res.base_seq          = out_base_reg;
    assign res.last              = out_last_reg;

endmodule

// File: src/gbn_checker.sv
// Port-level checks for the Go-Back-N sender window core, and their bind.
// Depends on gbn_pkg; attaches to go_back_n_sender_window_core.
module gbn_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_ready,
    input  logic                       res_valid,
    input  logic                       res_ready,
    input  logic [gbn_pkg::KIND_W-1:0] res_kind,
    input  logic [gbn_pkg::SEQ_W-1:0]  res_frame_seq,
    input  logic [gbn_pkg::SEQ_W-1:0]  res_outstanding_count,
    input  logic                       res_last
);
    import gbn_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) && $stable(res_frame_seq))
        else $error("stalled result changed");

    // A new data frame always leaves at least one frame outstanding.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_NEW) |-> (res_outstanding_count != '0))
        else $error("new frame with empty window");

    // Resent frames only come from a non-empty window.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_RETX) |-> (res_outstanding_count != '0))
        else $error("resend with empty window");

    // While a resend burst is still running, no new item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> !req_ready)
        else $error("item taken during a resend burst");

    // Only a resend burst has results that are not the last of their item.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_last |-> (res_kind == KIND_RETX))
        else $error("non-final result outside a resend");

endmodule

bind go_back_n_sender_window_core gbn_checker u_gbn_checker
(
    .clk                   (clk),
    .rst_n                 (rst_n),
    .req_ready             (req.ready),
    .res_valid             (res.valid),
    .res_ready             (res.ready),
    .res_kind              (res.kind),
    .res_frame_seq         (res.frame_seq),
    .res_outstanding_count (res.outstanding_count),
    .res_last              (res.last)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Go-Back-N sender window core.
// Depends on gbn_pkg, the channel interfaces in gbn_if.sv and the core itself.
module tb;
    import gbn_pkg::*;

    // One emitted frame or acknowledgement verdict, field by field.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [SEQ_W-1:0]  outst;
        logic [SEQ_W-1:0]  base;
        logic              last;
    } frame_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_op_t;

    // One line of the directed plan: an item or a register write.
    typedef struct packed {
        row_op_t               op;
        logic [MODE_W-1:0]     mode;
        logic [LEN_W-1:0]      plen;
        logic [SEQ_W-1:0]      ack;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  chk;
        frame_t                want;
    } row_t;

    localparam frame_t NO_FRAME = '0;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    gbn_req_if req_ch ();
    gbn_res_if res_ch ();

    go_back_n_sender_window_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    // Window model state, kept in step with every accepted item.
    logic [WIN_W-1:0] win_q;
    logic [TMO_W-1:0] tmo_q;
    logic [SEQ_W-1:0] base_q;
    logic [SEQ_W-1:0] next_q;
    logic [SEQ_W-1:0] outst_q;
    logic [TMO_W-1:0] timer_q;
    logic [LEN_W-1:0] len_mem [SEQ_MOD];

    frame_t frames_due [$];
    int     bad_frames;
    int     idle_pct;
    int     stall_pct;
    logic   fixed_chk;
    frame_t fixed_frame;
    row_t   plan [29];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("[go_back_n_sender_window_core] ERROR");
        $finish;
    end

    function automatic void queue_frame(input logic [KIND_W-1:0] k, input logic [SEQ_W-1:0] s,
                                        input logic [LEN_W-1:0] l);
        frame_t f;
        f = '{k, s, l, outst_q, base_q, 1'b0};
        frames_due.push_back(f);
    endfunction

    // Advances the window model by one item and queues the frames it causes.
    function automatic void predict_window(input logic [MODE_W-1:0] m,
                                           input logic [LEN_W-1:0] pl,
                                           input logic [SEQ_W-1:0] ak);
        logic [SEQ_W-1:0] win;
        logic [SEQ_W-1:0] off;
        logic [SEQ_W-1:0] s;
        logic [TMO_W-1:0] lim;
        logic [LEN_W-1:0] len;
        int due_start;
        int i;
        frame_t tail;
        win = (win_q < SEQ_MASK) ? win_q : SEQ_MASK;
        lim = (tmo_q == 0) ? TMO_W'(1) : tmo_q;
        len = (pl > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : pl;
        due_start = frames_due.size();
        case (m)
            MODE_SEND:
            begin
                if (outst_q < win)
                begin
                    s = next_q;
                    len_mem[s] = len;
                    if (outst_q == 0)
                        timer_q = '0;
                    next_q = next_q + 1'b1;
                    outst_q = outst_q + 1'b1;
                    queue_frame(KIND_NEW, s, len);
                end
                else
                    queue_frame(KIND_REJECT, next_q, '0);
            end
            MODE_ACK:
            begin
                off = ak - base_q;
                if (off < outst_q)
                begin
                    base_q = ak + 1'b1;
                    outst_q = outst_q - off - 1'b1;
                    timer_q = '0;
                    queue_frame(KIND_ACK_OK, ak, '0);
                end
                else
                    queue_frame(KIND_ACK_IGN, ak, '0);
            end
            MODE_TICK:
            begin
                if (outst_q == 0)
                    timer_q = '0;
                else
                begin
                    if (timer_q != '1)
                        timer_q = timer_q + 1'b1;
                    if (timer_q >= lim)
                    begin
                        timer_q = '0;
                        for (i = 0; i < outst_q && i < 7; i++)
                        begin
                            s = base_q + SEQ_W'(i);
                            queue_frame(KIND_RETX, s, len_mem[s]);
                        end
                    end
                end
            end
            MODE_END:
            begin
                if (outst_q == 0)
                    queue_frame(KIND_END, next_q, '0);
                else
                    queue_frame(KIND_REJECT, next_q, '0);
            end
        endcase
        // Mark the final frame of this item.
        if (frames_due.size() > due_start)
        begin
            tail = frames_due.pop_back();
            tail.last = 1'b1;
            frames_due.push_back(tail);
        end
    endfunction

    // Receiver side: random back-pressure at the rate of the current phase.
    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watch both channels: predict on each accepted item, check each accepted frame.
    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_window(req_ch.mode, req_ch.payload_length, req_ch.ack_seq);
                // Hand-written expectations take the place of the predicted one.
                if (fixed_chk && frames_due.size() != 0)
                begin
                    want = frames_due.pop_back();
                    frames_due.push_back(fixed_frame);
                end
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got = '{res_ch.kind, res_ch.frame_seq, res_ch.frame_length,
                        res_ch.outstanding_count, res_ch.base_seq, res_ch.last};
                if (frames_due.size() == 0)
                begin
                    bad_frames++;
                    if (bad_frames <= 10)
                        $display("unexpected frame: kind %0d seq %0d len %0d out %0d base %0d last %0d",
                                 got.kind, got.seq, got.len, got.outst, got.base, got.last);
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got !== want)
                    begin
                        bad_frames++;
                        if (bad_frames <= 10)
                            $display({"frame mismatch: expected kind %0d seq %0d len %0d out %0d ",
                                      "base %0d last %0d, got kind %0d seq %0d len %0d out %0d ",
                                      "base %0d last %0d"},
                                     want.kind, want.seq, want.len, want.outst, want.base,
                                     want.last, got.kind, got.seq, got.len, got.outst,
                                     got.base, got.last);
                    end
                end
            end
        end
    end

    // Offers one item after a random gap and holds it until it is taken.
    task automatic drive_item(input logic [MODE_W-1:0] m, input logic [LEN_W-1:0] pl,
                              input logic [SEQ_W-1:0] ak, input logic chk, input frame_t want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.mode           <= m;
        req_ch.payload_length <= pl;
        req_ch.ack_seq        <= ak;
        fixed_chk             <= chk;
        fixed_frame           <= want;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Stops offering items and waits until every frame due has come out.
    task automatic settle();
        req_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW)
            win_q = data[WIN_W-1:0];
        else
            tmo_q = data[TMO_W-1:0];
        @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int k;
        int r;
        int pick;
        logic [MODE_W-1:0] m;
        logic [LEN_W-1:0]  pl;
        logic [SEQ_W-1:0]  ak;
        logic [WIN_W-1:0]  win;
        logic [TMO_W-1:0]  tmo;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_wdata             = '0;
        req_ch.valid          = 1'b0;
        req_ch.mode           = MODE_SEND;
        req_ch.payload_length = '0;
        req_ch.ack_seq        = '0;
        res_ch.ready          = 1'b0;
        fixed_chk             = 1'b0;
        fixed_frame           = NO_FRAME;
        bad_frames            = 0;
        idle_pct              = 0;
        stall_pct             = 0;
        win_q                 = WIN_RESET;
        tmo_q                 = TMO_RESET;
        base_q                = '0;
        next_q                = '0;
        outst_q               = '0;
        timer_q               = '0;
        for (r = 0; r < SEQ_MOD; r++)
            len_mem[r] = '0;

        // Directed plan: idle corner cases, a full window, saturation, resends and wrap.
        plan = '{
            '{ROW_ITEM, MODE_END,  5'd0,  3'd0, CFG_WINDOW,  16'd0,     1'b1,
              '{KIND_END,     3'd0, 5'd0,  3'd0, 3'd0, 1'b1}},
            '{ROW_ITEM, MODE_ACK,  5'd0,  3'd7, CFG_WINDOW,  16'd0,     1'b1,
              '{KIND_ACK_IGN, 3'd7, 5'd0,  3'd0, 3'd0, 1'b1}},
            '{ROW_ITEM, MODE_TICK, 5'd31, 3'd5, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_CFG,  MODE_SEND, 5'd0,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_SEND, 5'd5,  3'd0, CFG_WINDOW,  16'd0,     1'b1,
              '{KIND_REJECT,  3'd0, 5'd0,  3'd0, 3'd0, 1'b1}},
            '{ROW_CFG,  MODE_SEND, 5'd0,  3'd0, CFG_WINDOW,  16'd7,     1'b0, NO_FRAME},
            '{ROW_CFG,  MODE_SEND, 5'd0,  3'd0, CFG_TIMEOUT, 16'd1,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_SEND, 5'd0,  3'd0, CFG_WINDOW,  16'd0,     1'b1,
              '{KIND_NEW,     3'd0, 5'd0,  3'd1, 3'd0, 1'b1}},
            '{ROW_ITEM, MODE_SEND, 5'd31, 3'd0, CFG_WINDOW,  16'd0,     1'b1,
              '{KIND_NEW,     3'd1, 5'd30, 3'd2, 3'd0, 1'b1}},
            '{ROW_ITEM, MODE_SEND, 5'd30, 3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_SEND, 5'd1,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_SEND, 5'd17, 3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_SEND, 5'd8,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_SEND, 5'd3,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_SEND, 5'd2,  3'd0, CFG_WINDOW,  16'd0,     1'b1,
              '{KIND_REJECT,  3'd7, 5'd0,  3'd7, 3'd0, 1'b1}},
            '{ROW_ITEM, MODE_END,  5'd0,  3'd0, CFG_WINDOW,  16'd0,     1'b1,
              '{KIND_REJECT,  3'd7, 5'd0,  3'd7, 3'd0, 1'b1}},
            '{ROW_ITEM, MODE_TICK, 5'd0,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_ACK,  5'd0,  3'd7, CFG_WINDOW,  16'd0,     1'b1,
              '{KIND_ACK_IGN, 3'd7, 5'd0,  3'd7, 3'd0, 1'b1}},
            '{ROW_ITEM, MODE_ACK,  5'd0,  3'd2, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_ACK,  5'd0,  3'd1, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_CFG,  MODE_SEND, 5'd0,  3'd0, CFG_TIMEOUT, 16'hFFFF,  1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_TICK, 5'd0,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_CFG,  MODE_SEND, 5'd0,  3'd0, CFG_TIMEOUT, 16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_TICK, 5'd0,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_ACK,  5'd0,  3'd6, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_SEND, 5'd21, 3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_SEND, 5'd9,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_ACK,  5'd0,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME},
            '{ROW_ITEM, MODE_END,  5'd0,  3'd0, CFG_WINDOW,  16'd0,     1'b0, NO_FRAME}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < 29; r++)
        begin
            if (plan[r].op == ROW_CFG)
            begin
                settle();
                write_reg(plan[r].idx, plan[r].data);
            end
            else
                drive_item(plan[r].mode, plan[r].plen, plan[r].ack, plan[r].chk, plan[r].want);
        end

        // Random phases, each with its own idling pattern and register setting.
        for (ph = 0; ph < 4; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                    win = WIN_W'($urandom_range(7, 1));
                    tmo = TMO_W'($urandom_range(4, 1));
                end
                1:
                begin
                    idle_pct  = 81;
                    stall_pct = 0;
                    win = WIN_W'(1);
                    tmo = TMO_W'(2);
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 81;
                    win = WIN_W'(7);
                    tmo = TMO_W'($urandom_range(3, 1));
                end
                default:
                begin
                    idle_pct  = 28;
                    stall_pct = 28;
                    win = WIN_W'($urandom_range(7, 0));
                    tmo = TMO_W'($urandom_range(3, 0));
                end
            endcase
            // Upper bits of the window write carry noise that the block must drop.
            write_reg(CFG_WINDOW, {(CFG_DATA_W - WIN_W)'($urandom), win});
            write_reg(CFG_TIMEOUT, tmo);

            for (k = 0; k < 88; k++)
            begin
                // Halfway through, pause until every frame due has come out.
                if (k == 44)
                    settle();
                pick = $urandom_range(99);
                pl = LEN_W'($urandom);
                ak = SEQ_W'($urandom);
                if (pick < 40)
                    m = MODE_SEND;
                else if (pick < 70)
                begin
                    m = MODE_ACK;
                    // Mostly acknowledge a frame that is actually outstanding.
                    if (outst_q != 0 && $urandom_range(3) != 0)
                        ak = base_q + SEQ_W'($urandom_range(int'(outst_q) - 1));
                end
                else if (pick < 92)
                    m = MODE_TICK;
                else
                    m = MODE_END;
                drive_item(m, pl, ak, 1'b0, NO_FRAME);
            end
        end

        settle();
        if (bad_frames == 0 && frames_due.size() == 0)
            $display("[go_back_n_sender_window_core] OK");
        else
            $display("[go_back_n_sender_window_core] ERROR");
        $finish;
    end

endmodule
